// ===== rtl/scd_pkg.sv =====
`timescale 1ns / 1ps

package scd_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_POSTED   = 3'd1,
    ST_NODEV    = 3'd2,
    ST_INVREQ   = 3'd3,
    ST_INTERR   = 3'd4,
    ST_BADBLOCK = 3'd5,
    ST_BADFIELD = 3'd6
  } status_e;

  // command classes
  typedef enum logic [3:0] {
    KIND_LUNS    = 4'd0,
    KIND_TUR     = 4'd1,
    KIND_INQ     = 4'd2,
    KIND_CAP10   = 4'd3,
    KIND_CAP16   = 4'd4,
    KIND_READ    = 4'd5,
    KIND_WRITE   = 4'd6,
    KIND_FLUSH   = 4'd7,
    KIND_UNMAP   = 4'd8,
    KIND_INVALID = 4'd9
  } kind_e;

  // opcodes
  localparam logic [7:0] OP_TUR      = 8'h00;
  localparam logic [7:0] OP_READ6    = 8'h08;
  localparam logic [7:0] OP_WRITE6   = 8'h0A;
  localparam logic [7:0] OP_INQUIRY  = 8'h12;
  localparam logic [7:0] OP_CAP10    = 8'h25;
  localparam logic [7:0] OP_READ10   = 8'h28;
  localparam logic [7:0] OP_WRITE10  = 8'h2A;
  localparam logic [7:0] OP_SYNC10   = 8'h35;
  localparam logic [7:0] OP_UNMAP    = 8'h42;
  localparam logic [7:0] OP_READ16   = 8'h88;
  localparam logic [7:0] OP_WRITE16  = 8'h8A;
  localparam logic [7:0] OP_SYNC16   = 8'h91;
  localparam logic [7:0] OP_SA_IN    = 8'h9E;
  localparam logic [7:0] OP_LUNS     = 8'hA0;
  localparam logic [7:0] OP_READ12   = 8'hA8;
  localparam logic [7:0] OP_WRITE12  = 8'hAA;

  localparam logic [4:0] SA_CAP16    = 5'h10;

  // opcode group field (opcode bits 7:5)
  localparam logic [2:0] GRP_SIX     = 3'b000;
  localparam logic [2:0] GRP_TEN_A   = 3'b001;
  localparam logic [2:0] GRP_TEN_B   = 3'b010;
  localparam logic [2:0] GRP_SIXTEEN = 3'b100;

  // inquiry vital product data pages that are served
  localparam logic [7:0] VPD_SUPPORTED = 8'h00;
  localparam logic [7:0] VPD_SERIAL    = 8'h80;
  localparam logic [7:0] VPD_DEVID     = 8'h83;
  localparam logic [7:0] VPD_LIMITS    = 8'hB0;
  localparam logic [7:0] VPD_PROVISION = 8'hB2;

  localparam logic [31:0] UNMAP_MIN_LEN   = 32'd8;
  localparam logic [31:0] SIX_ZERO_COUNT  = 32'd256;

  // register map
  localparam int unsigned  ADDR_W        = 5;
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_BLKSIZE  = 5'd8;
  localparam logic [ADDR_W-1:0] ADDR_MAXXFER  = 5'd16;

  localparam logic [63:0] CAPACITY_RST = 64'd0;
  localparam logic [31:0] BLKSIZE_RST  = 32'd512;
  localparam logic [31:0] MAXXFER_RST  = 32'd65536;

  // decoded command, first stage output
  typedef struct packed {
    kind_e       kind;
    status_e     status;   // final status unless chk is set
    logic        chk;      // unit present and read, write or flush
    logic        is_flush;
    logic        mul;      // byte length is counted (read or write)
    logic        buf_ok;
    logic [63:0] lba;
    logic [31:0] cnt;
    logic        fua;
  } dec_t;

endpackage

// ===== rtl/scd_decode.sv =====
`timescale 1ns / 1ps

module scd_decode (
  input  logic [63:0]  cdb_head_i,
  input  logic [63:0]  cdb_tail_i,
  input  logic         unit_present_i,
  input  logic         buffer_present_i,
  input  logic [31:0]  buffer_length_i,
  output scd_pkg::dec_t dec_o
);
  import scd_pkg::*;

  logic [7:0] op;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b4;
  logic       rw;
  kind_e      kind;
  status_e    status;
  logic [63:0] lba;
  logic [31:0] cnt;
  logic        fua;

  assign op = cdb_head_i[63:56];
  assign b1 = cdb_head_i[55:48];
  assign b2 = cdb_head_i[47:40];
  assign b4 = cdb_head_i[31:24];

  // opcode classification
  always_comb begin
    unique case (op) inside
      OP_LUNS:    kind = KIND_LUNS;
      OP_TUR:     kind = KIND_TUR;
      OP_INQUIRY: kind = KIND_INQ;
      OP_CAP10:   kind = KIND_CAP10;
      OP_SA_IN:   kind = (b1[4:0] == SA_CAP16) ? KIND_CAP16 : KIND_INVALID;
      OP_READ6, OP_READ10, OP_READ12, OP_READ16:     kind = KIND_READ;
      OP_WRITE6, OP_WRITE10, OP_WRITE12, OP_WRITE16: kind = KIND_WRITE;
      OP_SYNC10, OP_SYNC16: kind = KIND_FLUSH;
      OP_UNMAP:   kind = KIND_UNMAP;
      default:    kind = KIND_INVALID;
    endcase
  end

  assign rw = (kind == KIND_READ) || (kind == KIND_WRITE) || (kind == KIND_FLUSH);

  // block address and count layout by opcode group
  always_comb begin
    lba = '0;
    cnt = '0;
    fua = 1'b0;
    if (rw) begin
      case (op[7:5]) inside
        GRP_SIX: begin
          lba = {43'd0, b1[4:0], b2, cdb_head_i[39:32]};
          cnt = (b4 == 8'd0) ? SIX_ZERO_COUNT : {24'd0, b4};
        end
        GRP_TEN_A, GRP_TEN_B: begin
          lba = {32'd0, cdb_head_i[47:16]};
          cnt = {16'd0, cdb_head_i[7:0], cdb_tail_i[63:56]};
          fua = b1[3];
        end
        GRP_SIXTEEN: begin
          lba = {cdb_head_i[47:0], cdb_tail_i[63:48]};
          cnt = cdb_tail_i[47:16];
          fua = b1[3];
        end
        default: begin
          lba = {32'd0, cdb_head_i[47:16]};
          cnt = {cdb_head_i[15:0], cdb_tail_i[63:48]};
          fua = b1[3];
        end
      endcase
      if (kind == KIND_FLUSH) begin
        fua = 1'b0;
      end
    end
  end

  // status of everything but the buffer, limit and block range checks of reads, writes and flushes
  always_comb begin
    status = ST_DONE;
    if (!unit_present_i) begin
      if (kind == KIND_LUNS) begin
        status = buffer_present_i ? ST_DONE : ST_INTERR;
      end else begin
        status = ST_NODEV;
      end
    end else begin
      case (kind)
        KIND_LUNS, KIND_CAP10, KIND_CAP16: begin
          status = buffer_present_i ? ST_DONE : ST_INTERR;
        end
        KIND_TUR: status = ST_DONE;
        KIND_INQ: begin
          if (!buffer_present_i) begin
            status = ST_INTERR;
          end else if (b1[0]) begin
            status = (b2 == VPD_SUPPORTED || b2 == VPD_SERIAL || b2 == VPD_DEVID ||
                      b2 == VPD_LIMITS || b2 == VPD_PROVISION) ? ST_DONE : ST_BADFIELD;
          end else begin
            status = ST_DONE;
          end
        end
        KIND_UNMAP: begin
          if (!buffer_present_i || (buffer_length_i < UNMAP_MIN_LEN)) begin
            status = ST_INTERR;
          end else if (b1[0]) begin
            status = ST_BADFIELD;
          end else begin
            status = ST_POSTED;
          end
        end
        KIND_READ, KIND_WRITE, KIND_FLUSH: status = ST_DONE;
        default: status = ST_INVREQ;
      endcase
    end
  end

  assign dec_o.kind     = kind;
  assign dec_o.status   = status;
  assign dec_o.chk      = unit_present_i && rw;
  assign dec_o.is_flush = (kind == KIND_FLUSH);
  assign dec_o.mul      = (kind == KIND_READ) || (kind == KIND_WRITE);
  assign dec_o.buf_ok   = buffer_present_i;
  assign dec_o.lba      = lba;
  assign dec_o.cnt      = cnt;
  assign dec_o.fua      = fua;

endmodule

// ===== rtl/scsi_cdb_decode_and_range_check.sv =====
`timescale 1ns / 1ps

// each input item is registered in every stage before its result item is valid
// throughput: one item per cycle unless m_axis_tready stalls; stages are decode, multiply/add, compare
// the 32x32 length multiply and the 64-bit range compares set the stage depth
// reset: asynchronous, active low; clears pipeline valids and loads register
// defaults (capacity 0, block size 512, max transfer 65536)

module scsi_cdb_decode_and_range_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input item
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [63:0] cdb_head, [127:64] cdb_tail, [128] unit_present,
  // [129] buffer_present, [161:130] buffer_length, [167:162] zero
  input  logic [167:0]              s_axis_tdata,
  // result item
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [2:0] status, [6:3] command_kind, [70:7] start_block,
  // [102:71] block_total, [103] force_unit_access, [167:104] byte_length
  output logic [167:0]              m_axis_tdata,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [scd_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);
  import scd_pkg::*;

  // configuration registers
  logic [63:0] capacity_q;
  logic [31:0] blksize_q;
  logic [31:0] maxxfer_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RST;
      blksize_q  <= BLKSIZE_RST;
      maxxfer_q  <= MAXXFER_RST;
    end else if (cfg_wr) begin
      if (paddr == ADDR_CAPACITY) capacity_q <= pwdata;
      if (paddr == ADDR_BLKSIZE)  blksize_q  <= pwdata[31:0];
      if (paddr == ADDR_MAXXFER)  maxxfer_q  <= pwdata[31:0];
    end
  end

  // register read
  always_comb begin
    unique case (paddr)
      ADDR_CAPACITY: prdata = capacity_q;
      ADDR_BLKSIZE:  prdata = {32'd0, blksize_q};
      ADDR_MAXXFER:  prdata = {32'd0, maxxfer_q};
      default:       prdata = '0;
    endcase
  end

  // pipeline flow control
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: opcode decode and field extraction
  dec_t        dec_d;
  dec_t        dec1_q;
  logic [31:0] blen1_q;

  scd_decode u_decode (
    .cdb_head_i       (s_axis_tdata[63:0]),
    .cdb_tail_i       (s_axis_tdata[127:64]),
    .unit_present_i   (s_axis_tdata[128]),
    .buffer_present_i (s_axis_tdata[129]),
    .buffer_length_i  (s_axis_tdata[161:130]),
    .dec_o            (dec_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      dec1_q  <= dec_d;
      blen1_q <= s_axis_tdata[161:130];
    end
  end

  // stage 2: byte length product and end block sum
  logic [63:0] bytes_d;
  logic [64:0] end_d;
  dec_t        dec2_q;
  logic [31:0] blen2_q;
  logic [63:0] bytes2_q;
  logic [64:0] end2_q;

  assign bytes_d = dec1_q.mul ? (64'(dec1_q.cnt) * 64'(blksize_q)) : 64'd0;
  assign end_d   = {1'b0, dec1_q.lba} + {33'd0, dec1_q.cnt};

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      dec2_q   <= dec1_q;
      blen2_q  <= blen1_q;
      bytes2_q <= bytes_d;
      end2_q   <= end_d;
    end
  end

  // stage 3: buffer, limit and range checks
  status_e     status_d;
  status_e     status3_q;
  kind_e       kind3_q;
  logic [63:0] lba3_q;
  logic [31:0] cnt3_q;
  logic        fua3_q;
  logic [63:0] bytes3_q;

  always_comb begin
    status_d = dec2_q.status;
    if (dec2_q.chk) begin
      if (!dec2_q.is_flush && (!dec2_q.buf_ok || ({32'd0, blen2_q} < bytes2_q) ||
                               (bytes2_q > {32'd0, maxxfer_q}))) begin
        status_d = ST_INTERR;
      end else if (dec2_q.cnt == 32'd0) begin
        status_d = ST_DONE;
      end else if (end2_q[64] || (end2_q[63:0] > capacity_q)) begin
        status_d = ST_BADBLOCK;
      end else begin
        status_d = ST_POSTED;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      status3_q <= status_d;
      kind3_q   <= dec2_q.kind;
      lba3_q    <= dec2_q.lba;
      cnt3_q    <= dec2_q.cnt;
      fua3_q    <= dec2_q.fua;
      bytes3_q  <= bytes2_q;
    end
  end

  // result item
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {bytes3_q, fua3_q, cnt3_q, lba3_q, kind3_q, status3_q};

endmodule

// ===== sim/scsi_cdb_decode_and_range_check_tb.sv =====
`timescale 1ns / 1ps

module scsi_cdb_decode_and_range_check_tb;
  import scd_pkg::*;

  localparam int unsigned PIPE_LATENCY = 3;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // input item, laid out as on s_axis_tdata (last member in the lowest bits)
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] blen;
    logic        bufp;
    logic        unit;
    logic [63:0] tail;
    logic [63:0] head;
  } cmd_t;

  // result item, laid out as on m_axis_tdata
  typedef struct packed {
    logic [63:0] bytes;
    logic        fua;
    logic [31:0] cnt;
    logic [63:0] lba;
    kind_e       kind;
    status_e     status;
  } result_t;

  // expected command results, with a private copy of the register values
  class cdb_scoreboard;
    logic [63:0]  capacity;
    logic [31:0]  blk_size;
    logic [31:0]  max_xfer;
    result_t      expected_q[$];
    int unsigned  errors;
    int unsigned  print_limit;

    function new();
      capacity    = CAPACITY_RST;
      blk_size    = BLKSIZE_RST;
      max_xfer    = MAXXFER_RST;
      errors      = 0;
      print_limit = 100;
    endfunction

    function void set_register(logic [ADDR_W-1:0] addr, logic [63:0] value);
      case (addr)
        ADDR_CAPACITY: capacity = value;
        ADDR_BLKSIZE:  blk_size = value[31:0];
        ADDR_MAXXFER:  max_xfer = value[31:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= print_limit) $display("ERROR: %s", msg);
    endtask

    // decode and range check of one command block
    function result_t decode_command(cmd_t c);
      logic [127:0] cdb;
      logic [7:0]   op;
      logic [7:0]   b1;
      logic [7:0]   page;
      logic [64:0]  end_blk;
      result_t      r;
      cdb = {c.head, c.tail};
      op  = cdb[127:120];
      b1  = cdb[119:112];
      page = cdb[111:104];
      r.lba   = '0;
      r.cnt   = '0;
      r.fua   = 1'b0;
      r.bytes = '0;
      r.status = ST_DONE;
      case (op)
        OP_LUNS:    r.kind = KIND_LUNS;
        OP_TUR:     r.kind = KIND_TUR;
        OP_INQUIRY: r.kind = KIND_INQ;
        OP_CAP10:   r.kind = KIND_CAP10;
        OP_SA_IN:   r.kind = (b1[4:0] == SA_CAP16) ? KIND_CAP16 : KIND_INVALID;
        OP_READ6, OP_READ10, OP_READ12, OP_READ16:     r.kind = KIND_READ;
        OP_WRITE6, OP_WRITE10, OP_WRITE12, OP_WRITE16: r.kind = KIND_WRITE;
        OP_SYNC10, OP_SYNC16: r.kind = KIND_FLUSH;
        OP_UNMAP:   r.kind = KIND_UNMAP;
        default:    r.kind = KIND_INVALID;
      endcase

      // field layout follows the opcode group
      if (r.kind == KIND_READ || r.kind == KIND_WRITE || r.kind == KIND_FLUSH) begin
        case (op[7:5])
          GRP_SIX: begin
            r.lba = {43'd0, b1[4:0], cdb[111:96]};
            r.cnt = {24'd0, cdb[95:88]};
            if (r.cnt == 0) r.cnt = SIX_ZERO_COUNT;
          end
          GRP_TEN_A, GRP_TEN_B: begin
            r.lba = {32'd0, cdb[111:80]};
            r.cnt = {16'd0, cdb[71:56]};
            r.fua = b1[3];
          end
          GRP_SIXTEEN: begin
            r.lba = cdb[111:48];
            r.cnt = cdb[47:16];
            r.fua = b1[3];
          end
          default: begin
            r.lba = {32'd0, cdb[111:80]};
            r.cnt = cdb[79:48];
            r.fua = b1[3];
          end
        endcase
        if (r.kind == KIND_FLUSH) r.fua = 1'b0;
        else r.bytes = 64'(r.cnt) * 64'(blk_size);
      end

      // status
      if (!c.unit) begin
        if (r.kind == KIND_LUNS) r.status = c.bufp ? ST_DONE : ST_INTERR;
        else r.status = ST_NODEV;
      end else begin
        case (r.kind)
          KIND_LUNS, KIND_CAP10, KIND_CAP16: r.status = c.bufp ? ST_DONE : ST_INTERR;
          KIND_TUR: r.status = ST_DONE;
          KIND_INQ: begin
            if (!c.bufp) r.status = ST_INTERR;
            else if (b1[0])
              r.status = (page == VPD_SUPPORTED || page == VPD_SERIAL ||
                          page == VPD_DEVID || page == VPD_LIMITS ||
                          page == VPD_PROVISION) ? ST_DONE : ST_BADFIELD;
            else r.status = ST_DONE;
          end
          KIND_READ, KIND_WRITE, KIND_FLUSH: begin
            end_blk = {1'b0, r.lba} + {33'd0, r.cnt};
            if (r.kind != KIND_FLUSH &&
                (!c.bufp || {32'd0, c.blen} < r.bytes || r.bytes > {32'd0, max_xfer}))
              r.status = ST_INTERR;
            else if (r.cnt == 0) r.status = ST_DONE;
            else if (end_blk > {1'b0, capacity}) r.status = ST_BADBLOCK;
            else r.status = ST_POSTED;
          end
          KIND_UNMAP: begin
            if (!c.bufp || c.blen < UNMAP_MIN_LEN) r.status = ST_INTERR;
            else if (b1[0]) r.status = ST_BADFIELD;
            else r.status = ST_POSTED;
          end
          default: r.status = ST_INVREQ;
        endcase
      end
      return r;
    endfunction

    task note_command(cmd_t c);
      expected_q.push_back(decode_command(c));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, status %0d kind %0d",
                         got.status, got.kind));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.kind !== want.kind)
        report($sformatf("command_kind %0d, expected %0d", got.kind, want.kind));
      if (got.lba !== want.lba)
        report($sformatf("start_block %h, expected %h", got.lba, want.lba));
      if (got.cnt !== want.cnt)
        report($sformatf("block_total %h, expected %h", got.cnt, want.cnt));
      if (got.fua !== want.fua)
        report($sformatf("force_unit_access %b, expected %b", got.fua, want.fua));
      if (got.bytes !== want.bytes)
        report($sformatf("byte_length %h, expected %h", got.bytes, want.bytes));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [167:0]        s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [167:0]        m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [63:0]         pwdata = '0;
  logic [63:0]         prdata;
  logic                pready;

  int unsigned         dst_idle = 73;
  int unsigned         hold_token = 0;
  int unsigned         cycle_count = 0;
  cdb_scoreboard       sb = new();

  scsi_cdb_decode_and_range_check uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    int unsigned hold_seen;
    int unsigned hold_left;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // accepted items on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_command(cmd_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(result_t'(m_axis_tdata));
    end
  end

  // register write: setup cycle, then access cycle
  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(addr, data);
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] cap, input logic [31:0] bsize,
                            input logic [31:0] maxx);
    apb_write(ADDR_CAPACITY, cap);
    apb_write(ADDR_BLKSIZE, {32'd0, bsize});
    apb_write(ADDR_MAXXFER, {32'd0, maxx});
  endtask

  task automatic send_cmd(input cmd_t c, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // sender pauses until every result is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // places start block, count and fua at the byte positions of the opcode group
  function automatic logic [127:0] rw_cdb(input logic [7:0] op, input logic [63:0] lba,
                                          input logic [31:0] cnt, input logic fua,
                                          input logic [127:0] fill);
    logic [127:0] c;
    c = fill;
    c[127:120] = op;
    case (op[7:5])
      GRP_SIX: begin
        c[116:112] = lba[20:16];
        c[111:96]  = lba[15:0];
        c[95:88]   = cnt[7:0];
      end
      GRP_TEN_A, GRP_TEN_B: begin
        c[115]    = fua;
        c[111:80] = lba[31:0];
        c[71:56]  = cnt[15:0];
      end
      GRP_SIXTEEN: begin
        c[115]    = fua;
        c[111:48] = lba;
        c[47:16]  = cnt;
      end
      default: begin
        c[115]    = fua;
        c[111:80] = lba[31:0];
        c[79:48]  = cnt;
      end
    endcase
    return c;
  endfunction

  function automatic cmd_t make_cmd(input logic [127:0] cdb, input logic unit,
                                    input logic bufp, input logic [31:0] blen);
    cmd_t c;
    c.pad  = '0;
    {c.head, c.tail} = cdb;
    c.unit = unit;
    c.bufp = bufp;
    c.blen = blen;
    return c;
  endfunction

  // mostly well-formed reads, writes and flushes, some other opcodes, some noise
  function automatic cmd_t random_cmd();
    logic [127:0] cdb;
    logic [7:0]   op;
    logic [63:0]  lba;
    logic [31:0]  cnt;
    logic [63:0]  need;
    logic [31:0]  blen;
    int unsigned  pick;
    cdb  = {$urandom(), $urandom(), $urandom(), $urandom()};
    blen = $urandom();
    pick = $urandom_range(99);
    if (pick < 60) begin
      case ($urandom_range(9))
        0: op = OP_READ6;
        1: op = OP_READ10;
        2: op = OP_READ12;
        3: op = OP_READ16;
        4: op = OP_WRITE6;
        5: op = OP_WRITE10;
        6: op = OP_WRITE12;
        7: op = OP_WRITE16;
        8: op = OP_SYNC10;
        default: op = OP_SYNC16;
      endcase
      pick = $urandom_range(99);
      if (pick < 60) lba = 64'($urandom_range(2047));
      else if (pick < 80) lba = sb.capacity - 64'($urandom_range(300));
      else lba = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      if (pick < 50) cnt = $urandom_range(64);
      else if (pick < 75) cnt = $urandom_range(1024);
      else cnt = $urandom();
      cdb  = rw_cdb(op, lba, cnt, 1'($urandom_range(1)), cdb);
      need = 64'(cnt) * 64'(sb.blk_size);
      if ($urandom_range(99) < 70) blen = need[31:0] + $urandom_range(3);
    end else if (pick < 80) begin
      case ($urandom_range(5))
        0: op = OP_TUR;
        1: op = OP_INQUIRY;
        2: op = OP_CAP10;
        3: op = OP_SA_IN;
        4: op = OP_LUNS;
        default: op = OP_UNMAP;
      endcase
      cdb[127:120] = op;
      if (op == OP_SA_IN && $urandom_range(99) < 70) cdb[116:112] = SA_CAP16;
      if (op == OP_INQUIRY && $urandom_range(99) < 60) begin
        case ($urandom_range(4))
          0: cdb[111:104] = VPD_SUPPORTED;
          1: cdb[111:104] = VPD_SERIAL;
          2: cdb[111:104] = VPD_DEVID;
          3: cdb[111:104] = VPD_LIMITS;
          default: cdb[111:104] = VPD_PROVISION;
        endcase
      end
      if (op == OP_UNMAP) begin
        if ($urandom_range(99) < 50) cdb[112] = 1'b0;
        if ($urandom_range(99) < 50) blen = $urandom_range(16);
      end
    end
    return make_cmd(cdb, $urandom_range(99) < 90, $urandom_range(99) < 90, blen);
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned idle_pct);
    for (int unsigned i = 0; i < count; i++) send_cmd(random_cmd(), idle_pct);
  endtask

  // directed commands for capacity 1000, block size 512, max transfer 1 MiB
  task automatic run_directed(input int unsigned idle_pct);
    cmd_t q[$];
    q.push_back(make_cmd('0, 1'b1, 1'b1, 32'd0));
    q.push_back(make_cmd({OP_TUR, 120'd0}, 1'b0, 1'b1, 32'd0));
    q.push_back(make_cmd({OP_LUNS, 120'd0}, 1'b0, 1'b1, 32'd64));
    q.push_back(make_cmd({OP_LUNS, 120'd0}, 1'b0, 1'b0, 32'd64));
    q.push_back(make_cmd({OP_INQUIRY, 8'h01, VPD_DEVID, 104'd0}, 1'b1, 1'b1, 32'd255));
    q.push_back(make_cmd({OP_INQUIRY, 8'h01, 8'h01, 104'd0}, 1'b1, 1'b1, 32'd255));
    q.push_back(make_cmd({OP_INQUIRY, 120'd0}, 1'b1, 1'b0, 32'd0));
    q.push_back(make_cmd({OP_CAP10, 120'd0}, 1'b1, 1'b1, 32'd8));
    q.push_back(make_cmd({OP_SA_IN, 3'd0, SA_CAP16, 112'd0}, 1'b1, 1'b1, 32'd32));
    q.push_back(make_cmd({OP_SA_IN, 3'd0, 5'h11, 112'd0}, 1'b1, 1'b1, 32'd32));
    // six-byte count byte of zero stands for 256 blocks
    q.push_back(make_cmd(rw_cdb(OP_READ6, 64'd0, 32'd0, 1'b0, '0), 1'b1, 1'b1,
                         32'd131072));
    // range ends exactly at capacity, then one past it
    q.push_back(make_cmd(rw_cdb(OP_WRITE10, 64'd990, 32'd10, 1'b1, '0), 1'b1, 1'b1,
                         32'hFFFF_FFFF));
    q.push_back(make_cmd(rw_cdb(OP_READ10, 64'd991, 32'd10, 1'b0, '0), 1'b1, 1'b1,
                         32'd8192));
    q.push_back(make_cmd(rw_cdb(OP_READ12, 64'd7, 32'd0, 1'b0, '0), 1'b1, 1'b1, 32'd0));
    // start plus count wraps 64 bits
    q.push_back(make_cmd(rw_cdb(OP_WRITE16, '1, 32'd2, 1'b0, '0), 1'b1, 1'b1, 32'd4096));
    q.push_back(make_cmd(rw_cdb(OP_READ16, 64'd0, 32'd8, 1'b1, '0), 1'b1, 1'b1,
                         32'd4095));
    q.push_back(make_cmd(rw_cdb(OP_WRITE10, 64'd1, 32'd1, 1'b0, '0), 1'b1, 1'b0,
                         32'd512));
    q.push_back(make_cmd(rw_cdb(OP_READ10, 64'd0, 32'd4096, 1'b0, '0), 1'b1, 1'b1,
                         32'hFFFF_FFFF));
    q.push_back(make_cmd(rw_cdb(OP_SYNC10, 64'd5, 32'd0, 1'b0, '0), 1'b1, 1'b0, 32'd0));
    q.push_back(make_cmd(rw_cdb(OP_SYNC16, 64'd100, 32'd10, 1'b1, '0), 1'b1, 1'b0,
                         32'd0));
    q.push_back(make_cmd({OP_UNMAP, 120'd0}, 1'b1, 1'b1, UNMAP_MIN_LEN));
    q.push_back(make_cmd({OP_UNMAP, 120'd0}, 1'b1, 1'b1, 32'd7));
    q.push_back(make_cmd({OP_UNMAP, 8'h01, 112'd0}, 1'b1, 1'b1, 32'd24));
    q.push_back(make_cmd('1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    q.push_back(make_cmd(rw_cdb(OP_WRITE6, 64'h1F_FFFF, 32'd255, 1'b0, '0), 1'b0, 1'b1,
                         32'd1024));
    foreach (q[i]) send_cmd(q[i], idle_pct);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, sender idles less than the receiver
    run_random(100, 31);
    wait_idle();
    set_config(64'd1000, 32'd512, 32'd1048576);
    run_directed(31);
    wait_idle();
    set_config(64'd1048576, 32'd4096, 32'd4194304);
    run_random(300, 31);

    // long receiver hold-off while the sender keeps offering
    hold_token <= hold_token + 1;
    run_random(50, 0);
    wait_idle();

    // receiver idles less than the sender
    dst_idle <= 31;
    set_config('1, 32'd1, 32'hFFFF_FFFF);
    run_random(350, 73);
    wait_idle();
    set_config(64'h1_0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(300, 73);
    wait_idle();

    // no idling on either side
    dst_idle <= 0;
    set_config(64'd5000, 32'd520, 32'd0);
    run_random(250, 0);
    wait_idle();
    set_config(64'hFFFF_FFFF, 32'd512, 32'd1048576);
    run_random(600, 0);
    wait_idle();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
